FILE: rtl/dlf_pkg.sv
// dlf_pkg: shared types, widths and codes of the dense layer forward pass
// no dependencies; imported by dlf_mac and dense_layer_forward_pass
`timescale 1ns / 1ps
`default_nettype none

package dlf_pkg;

   // fixed field widths
   localparam int KIND_W     = 2;
   localparam int ADDR_W     = 10;
   localparam int VALUE_W    = 16;
   localparam int INDEX_W    = 4;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;
   localparam int LC_REG_W   = 3;
   localparam int NODES_REG_W = 5;
   localparam int PROD_W     = 2 * VALUE_W;
   localparam int FRAC_BITS  = 8;

   // command kinds
   localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NODE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_LAYER_COUNT = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_LAYER0      = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_LAYER1      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_LAYER2      = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_LAYER3      = 3'd4;

   // register reset values
   localparam logic [LC_REG_W-1:0]    LAYER_COUNT_RST = 3'd2;
   localparam logic [NODES_REG_W-1:0] LAYER_NODES_RST = 5'd16;

   // node count used for layers that have no register
   localparam int DEFAULT_NODES = 16;

   typedef logic signed [VALUE_W-1:0] value_type;

   // control from the sequencer to the mac datapath
   typedef struct packed {
      logic valid;   // memory read data present this cycle
      logic clear;   // restart the accumulator
   } mac_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/dlf_mac.sv
// dlf_mac: multiply, accumulate, scale by 2^-8 and saturate to Q8.8
// depends on dlf_pkg
`timescale 1ns / 1ps
`default_nettype none

module dlf_mac #(
   parameter int ACC_W = 37
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dlf_pkg::mac_ctrl_type ctrl,
   input  wire dlf_pkg::value_type    weight_data,
   input  wire dlf_pkg::value_type    node_data,
   output logic                       pipe_busy,
   output dlf_pkg::value_type         result
);
   import dlf_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_valid_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  shifted;

   // product stage
   assign prod_in = weight_data * node_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctrl.valid;
      end
      prod_ff <= prod_in;
   end

   // accumulate stage
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // floor shift and saturate
   always_comb begin
      shifted = acc_ff >>> FRAC_BITS;
      if (shifted > ACC_W'(32'sd32767)) begin
         result = 16'sh7fff;
      end else if (shifted < ACC_W'(-32'sd32768)) begin
         result = 16'sh8000;
      end else begin
         result = shifted[VALUE_W-1:0];
      end
   end

   assign pipe_busy = ctrl.valid | prod_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/dense_layer_forward_pass.sv
// dense_layer_forward_pass: chained dense layers on one mac; depends on dlf_pkg and dlf_mac
// A weight or input write is accepted only while idle. A run holds busy over every layer:
// one mac fed by one read port per memory, with per node the reads of its inputs, then the
// drain states DRAIN1 and DRAIN2 and a write-back state.
// Each last-layer node is strobed out the cycle after its write back; the receiver cannot stall.
// Synchronous reset clears control and registers; memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module dense_layer_forward_pass #(
   parameter int MAX_LAYERS   = 4,
   parameter int MAX_NODES    = 16,
   parameter int WEIGHT_DEPTH = 1024,
   parameter int NODE_DEPTH   = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // command channel
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [dlf_pkg::KIND_W-1:0]         req_kind,
   input  wire logic [dlf_pkg::ADDR_W-1:0]         req_address,
   input  wire dlf_pkg::value_type                 req_value,
   // result channel
   output logic                                    rsp_strobe,
   output logic [dlf_pkg::INDEX_W-1:0]             rsp_node_index,
   output dlf_pkg::value_type                      rsp_node_value,
   output logic                                    rsp_last,
   // register port
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [dlf_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [dlf_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [dlf_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                    pready
);
   import dlf_pkg::*;

   localparam int WA_W   = $clog2(WEIGHT_DEPTH);
   localparam int NA_W   = $clog2(NODE_DEPTH);
   localparam int CNT_W  = $clog2(MAX_NODES + 1);
   localparam int LC_W   = $clog2(MAX_LAYERS + 1);
   localparam int LIDX_W = $clog2(MAX_LAYERS);
   localparam int ACC_W  = PROD_W + $clog2(MAX_NODES) + 1;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ISSUE  = 3'd1;
   localparam logic [2:0] ST_DRAIN1 = 3'd2;
   localparam logic [2:0] ST_DRAIN2 = 3'd3;
   localparam logic [2:0] ST_WRITE  = 3'd4;

   // reduce a 10-bit address modulo a depth by compare and subtract
   function automatic int wrap_addr(input int x, input int depth);
      int r;
      r = x;
      for (int k = ADDR_W - 1; k >= 0; k--) begin
         if (r >= (depth << k)) begin
            r = r - (depth << k);
         end
      end
      return r;
   endfunction

   // configuration registers
   logic [LC_REG_W-1:0]    layer_count_ff;
   logic [NODES_REG_W-1:0] layer_nodes_ff [4];
   logic                   csr_wr;
   logic [REG_IDX_W-1:0]   csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_count_ff <= LAYER_COUNT_RST;
         for (int n = 0; n < 4; n++) begin
            layer_nodes_ff[n] <= LAYER_NODES_RST;
         end
      end else if (csr_wr) begin
         case (csr_idx)
            REG_LAYER_COUNT: layer_count_ff    <= pwdata[LC_REG_W-1:0];
            REG_LAYER0:      layer_nodes_ff[0] <= pwdata[NODES_REG_W-1:0];
            REG_LAYER1:      layer_nodes_ff[1] <= pwdata[NODES_REG_W-1:0];
            REG_LAYER2:      layer_nodes_ff[2] <= pwdata[NODES_REG_W-1:0];
            REG_LAYER3:      layer_nodes_ff[3] <= pwdata[NODES_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (csr_idx)
         REG_LAYER_COUNT: prdata = CSR_DATA_W'(layer_count_ff);
         REG_LAYER0:      prdata = CSR_DATA_W'(layer_nodes_ff[0]);
         REG_LAYER1:      prdata = CSR_DATA_W'(layer_nodes_ff[1]);
         REG_LAYER2:      prdata = CSR_DATA_W'(layer_nodes_ff[2]);
         REG_LAYER3:      prdata = CSR_DATA_W'(layer_nodes_ff[3]);
         default:         prdata = '0;
      endcase
   end

   // clamped layer and node counts
   logic [LC_W-1:0]  num_layers;
   logic [CNT_W-1:0] eff_nodes [MAX_LAYERS];

   always_comb begin
      int raw;
      raw = int'(layer_count_ff);
      if (raw < 2) raw = 2;
      if (raw > MAX_LAYERS) raw = MAX_LAYERS;
      num_layers = LC_W'(raw);
      for (int l = 0; l < MAX_LAYERS; l++) begin
         raw = (l < 4) ? int'(layer_nodes_ff[l[1:0]]) : DEFAULT_NODES;
         if (raw < 1) raw = 1;
         if (raw > MAX_NODES) raw = MAX_NODES;
         eff_nodes[l] = CNT_W'(raw);
      end
   end

   // sequencer state
   logic [2:0]        state_ff, state_in;
   logic [LIDX_W-1:0] layer_ff, layer_in;
   logic [CNT_W-1:0]  inr_ff, inr_in, onr_ff, onr_in;
   logic [CNT_W-1:0]  row_ff, row_in, col_ff, col_in;
   logic [WA_W-1:0]   w_ptr_ff, w_ptr_in;
   logic [NA_W-1:0]   rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [NA_W-1:0]   in_base_ff, in_base_in, out_base_ff, out_base_in;
   logic              rd_valid_ff;
   logic              rsp_strobe_ff, rsp_strobe_in, rsp_last_ff, rsp_last_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   value_type         rsp_value_ff, rsp_value_in;

   logic              accept;
   logic              last_layer, row_done, col_done;
   logic [WA_W-1:0]   w_ptr_inc;
   logic [NA_W-1:0]   rd_ptr_inc, wr_ptr_inc;
   logic [LIDX_W-1:0] next_onr_idx;

   // mac datapath
   mac_ctrl_type mac_ctrl;
   value_type    w_rdata_ff, n_rdata_ff, mac_result;
   logic         mac_busy;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   assign last_layer   = (int'(layer_ff) + 2 == int'(num_layers));
   assign row_done     = (CNT_W'(row_ff + 1'b1) == onr_ff);
   assign col_done     = (CNT_W'(col_ff + 1'b1) == inr_ff);
   assign next_onr_idx = LIDX_W'(int'(layer_ff) + 2);

   // pointer increments that wrap at the memory depth
   assign w_ptr_inc  = (w_ptr_ff == WA_W'(WEIGHT_DEPTH - 1)) ? '0 : WA_W'(w_ptr_ff + 1'b1);
   assign rd_ptr_inc = (rd_ptr_ff == NA_W'(NODE_DEPTH - 1)) ? '0 : NA_W'(rd_ptr_ff + 1'b1);
   assign wr_ptr_inc = (wr_ptr_ff == NA_W'(NODE_DEPTH - 1)) ? '0 : NA_W'(wr_ptr_ff + 1'b1);

   always_comb begin
      state_in      = state_ff;
      layer_in      = layer_ff;
      inr_in        = inr_ff;
      onr_in        = onr_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      w_ptr_in      = w_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      in_base_in    = in_base_ff;
      out_base_in   = out_base_ff;
      rsp_strobe_in = 1'b0;
      rsp_last_in   = 1'b0;
      rsp_index_in  = INDEX_W'(row_ff);
      rsp_value_in  = mac_result;
      case (state_ff)
         ST_IDLE: begin
            // a run starts at layer 0 with its outputs right after the input nodes
            if (accept && req_kind == KIND_RUN) begin
               state_in    = ST_ISSUE;
               layer_in    = '0;
               inr_in      = eff_nodes[0];
               onr_in      = eff_nodes[1];
               row_in      = '0;
               col_in      = '0;
               w_ptr_in    = '0;
               rd_ptr_in   = '0;
               in_base_in  = '0;
               out_base_in = NA_W'(wrap_addr(int'(eff_nodes[0]), NODE_DEPTH));
               wr_ptr_in   = NA_W'(wrap_addr(int'(eff_nodes[0]), NODE_DEPTH));
            end
         end
         ST_ISSUE: begin
            // one weight and one node read per cycle
            w_ptr_in  = w_ptr_inc;
            rd_ptr_in = rd_ptr_inc;
            col_in    = CNT_W'(col_ff + 1'b1);
            if (col_done) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_WRITE;
         ST_WRITE: begin
            // node written back; last layer nodes also go out
            rsp_strobe_in = last_layer;
            rsp_last_in   = last_layer & row_done;
            wr_ptr_in     = wr_ptr_inc;
            col_in        = '0;
            if (!row_done) begin
               row_in    = CNT_W'(row_ff + 1'b1);
               rd_ptr_in = in_base_ff;
               state_in  = ST_ISSUE;
            end else if (last_layer) begin
               state_in = ST_IDLE;
            end else begin
               row_in      = '0;
               layer_in    = LIDX_W'(layer_ff + 1'b1);
               in_base_in  = out_base_ff;
               rd_ptr_in   = out_base_ff;
               out_base_in = wr_ptr_inc;
               inr_in      = onr_ff;
               onr_in      = eff_nodes[next_onr_idx];
               state_in    = ST_ISSUE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
         layer_ff      <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         inr_ff        <= '0;
         onr_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= (state_ff == ST_ISSUE);
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_last_ff   <= rsp_last_in;
         layer_ff      <= layer_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         inr_ff        <= inr_in;
         onr_ff        <= onr_in;
      end
      w_ptr_ff     <= w_ptr_in;
      rd_ptr_ff    <= rd_ptr_in;
      wr_ptr_ff    <= wr_ptr_in;
      in_base_ff   <= in_base_in;
      out_base_ff  <= out_base_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_node_index = rsp_index_ff;
   assign rsp_node_value = rsp_value_ff;

   // weight memory: written by weight transfers, read by the sequencer
   value_type       weight_mem [WEIGHT_DEPTH];
   logic [WA_W-1:0] w_wr_addr;

   assign w_wr_addr = WA_W'(wrap_addr(int'(req_address), WEIGHT_DEPTH));

   always_ff @(posedge clock) begin
      if (accept && req_kind == KIND_WEIGHT) begin
         weight_mem[w_wr_addr] <= req_value;
      end
      w_rdata_ff <= weight_mem[w_ptr_ff];
   end

   // node memory: input node transfers while idle, results while running
   value_type       node_mem [NODE_DEPTH];
   logic            n_wr_en;
   logic [NA_W-1:0] n_wr_addr;
   value_type       n_wr_data;

   always_comb begin
      if (state_ff == ST_WRITE) begin
         n_wr_en   = 1'b1;
         n_wr_addr = wr_ptr_ff;
         n_wr_data = mac_result;
      end else begin
         n_wr_en   = accept && req_kind == KIND_NODE
                     && (int'(req_address) < int'(eff_nodes[0]));
         n_wr_addr = NA_W'(wrap_addr(int'(req_address), NODE_DEPTH));
         n_wr_data = req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (n_wr_en) begin
         node_mem[n_wr_addr] <= n_wr_data;
      end
      n_rdata_ff <= node_mem[rd_ptr_ff];
   end

   assign mac_ctrl.valid = rd_valid_ff;
   assign mac_ctrl.clear = (state_ff == ST_WRITE);

   dlf_mac #(
      .ACC_W(ACC_W)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (mac_ctrl),
      .weight_data (w_rdata_ff),
      .node_data   (n_rdata_ff),
      .pipe_busy   (mac_busy),
      .result      (mac_result)
   );

   // the accumulator is complete before a node is written back
   a_write_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> !mac_busy)
      else $error("node written back while products are still in flight");

   // reads never run past the input layer of a row
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ISSUE |-> col_ff < inr_ff)
      else $error("read issued beyond the input layer");

   // the final node ends the run
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> !busy)
      else $error("last node reported while the run continues");

   // results only come from a run in progress
   a_strobe_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == ST_WRITE)
      else $error("result strobe outside a node write back");

endmodule

`default_nettype wire
